FILE: rtl/srfd_pkg.sv
// package: types, constants and config register codes for the stuffed register frame decoder
`timescale 1ns / 1ps
package srfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 2;
    localparam int CFG_IDX_W = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_XOR    = 2'd2;

    // config reset values
    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd126;
    localparam logic [BYTE_W-1:0] ESC_CODE_RST   = 8'd125;
    localparam logic [BYTE_W-1:0] ESC_XOR_RST    = 8'd32;

    // last payload byte index (four payload bytes per frame)
    localparam logic [IDX_W-1:0] LAST_PAYLOAD_IDX = 2'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_ADDR,
        PH_DATA,
        PH_SUM
    } t_phase;

    typedef struct packed {
        t_byte start_code;
        t_byte esc_code;
        t_byte esc_xor;
    } t_cfg;

    typedef struct packed {
        t_byte  reg_address;
        t_value reg_value;
        logic   checksum_ok;
    } t_result;

    typedef struct packed {
        logic   emit;
        t_phase phase;
    } t_frame_stat;

endpackage

FILE: rtl/srfd_byte_if.sv
// interface: received byte channel
`timescale 1ns / 1ps
interface srfd_byte_if;
    logic            valid;
    logic            ready;
    srfd_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/srfd_result_if.sv
// interface: decoded register write channel
`timescale 1ns / 1ps
interface srfd_result_if;
    logic             valid;
    logic             ready;
    srfd_pkg::t_byte  reg_address;
    srfd_pkg::t_value reg_value;
    logic             checksum_ok;

    modport source (output valid, output reg_address, output reg_value,
                    output checksum_ok, input ready);
    modport sink (input valid, input reg_address, input reg_value,
                  input checksum_ok, output ready);
endinterface

FILE: rtl/stuffed_register_frame_decoder.sv
// top level: byte-stuffed register frame decoder with additive checksum
//
//   channel   dir   width  payload
//   i_rx      in    8      rx_byte
//   o_res     out   41     reg_address, reg_value, checksum_ok
//   i_cfg_*   in    8      head byte, escape byte, escape mask (index 0..2)
//
// one byte per clock unless a full result register stalls the checksum byte; an
// accepted byte waits in the input register until it is processed, and a frame result
// is then loaded into the result register from its checksum byte
// synchronous active-low reset clears the frame state and the input and result valid flags and loads config defaults
// a full result register with a stalled sink holds back only the next checksum
// byte; that byte then blocks the input until the waiting result transfers
`timescale 1ns / 1ps
module stuffed_register_frame_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    srfd_byte_if.sink                      i_rx,
    srfd_result_if.source                  o_res,
    input  logic                           i_cfg_we,
    input  logic [srfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  srfd_pkg::t_byte                i_cfg_data
);
    srfd_pkg::t_cfg        w_cfg;
    logic                  w_in_valid;
    srfd_pkg::t_byte       w_in_byte;
    srfd_pkg::t_frame_stat w_stat;
    srfd_pkg::t_result     w_result;
    logic                  w_out_free;
    logic                  w_step;

    srfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    srfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_step),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    // process the held byte unless it would emit into a full result register
    assign w_step = w_in_valid && (!w_stat.emit || w_out_free);

    srfd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (w_in_byte),
        .i_cfg    (w_cfg),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    srfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step && w_stat.emit),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_res    (o_res)
    );

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_stat.emit) |-> w_out_free)
        else $error("result register overwritten");

    // a processed checksum byte shows up as a result next cycle
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_stat.emit) |=> o_res.valid)
        else $error("emitted frame not presented");

    // hunting stays in hunt on any byte other than the head byte
    a_hunt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (w_stat.phase == srfd_pkg::PH_WAIT) && (w_in_byte != w_cfg.start_code))
        |=> (w_stat.phase == srfd_pkg::PH_WAIT))
        else $error("left hunt without head byte");
endmodule

FILE: rtl/srfd_cfg.sv
// configuration registers: head byte, escape byte, escape mask
`timescale 1ns / 1ps
module srfd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  srfd_pkg::t_byte                i_cfg_data,
    output srfd_pkg::t_cfg                 o_cfg
);
    srfd_pkg::t_cfg r_cfg;
    srfd_pkg::t_cfg n_cfg;

    // register write decode, unknown indexes ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                srfd_pkg::CFG_START_CODE: n_cfg.start_code = i_cfg_data;
                srfd_pkg::CFG_ESC_CODE:   n_cfg.esc_code   = i_cfg_data;
                srfd_pkg::CFG_ESC_XOR:    n_cfg.esc_xor    = i_cfg_data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code <= srfd_pkg::START_CODE_RST;
            r_cfg.esc_code   <= srfd_pkg::ESC_CODE_RST;
            r_cfg.esc_xor    <= srfd_pkg::ESC_XOR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: rtl/srfd_in_stage.sv
// input register: holds one received byte until the frame logic takes it
`timescale 1ns / 1ps
module srfd_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srfd_byte_if.sink       i_rx,
    input  logic            i_take,
    output logic            o_valid,
    output srfd_pkg::t_byte o_byte
);
    logic            r_valid;
    srfd_pkg::t_byte r_byte;
    logic            w_load;

    // free when empty or when the held byte leaves this cycle
    assign i_rx.ready = !r_valid || i_take;
    assign w_load     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

FILE: rtl/srfd_frame.sv
// frame state machine: unstuffing, big-endian assembly and running checksum
`timescale 1ns / 1ps
module srfd_frame (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  srfd_pkg::t_byte       i_byte,
    input  srfd_pkg::t_cfg        i_cfg,
    output srfd_pkg::t_frame_stat o_stat,
    output srfd_pkg::t_result     o_result
);
    srfd_pkg::t_phase              r_phase, n_phase;
    srfd_pkg::t_byte               r_addr, n_addr;
    logic [srfd_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                          r_esc, n_esc;
    logic [srfd_pkg::VALUE_W-1:0]  r_value, n_value;
    srfd_pkg::t_byte               r_sum, n_sum;
    srfd_pkg::t_byte               w_data;

    // payload byte after unmasking
    assign w_data = r_esc ? (i_byte ^ i_cfg.esc_xor) : i_byte;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_idx   = r_idx;
        n_esc   = r_esc;
        n_value = r_value;
        n_sum   = r_sum;
        if (i_step) begin
            case (r_phase)
                srfd_pkg::PH_WAIT: begin
                    if (i_byte == i_cfg.start_code) begin
                        n_phase = srfd_pkg::PH_ADDR;
                        n_addr  = '0;
                        n_idx   = '0;
                        n_esc   = 1'b0;
                        n_value = '0;
                        n_sum   = '0;
                    end
                end
                srfd_pkg::PH_ADDR: begin
                    n_addr  = i_byte;
                    n_phase = srfd_pkg::PH_DATA;
                end
                srfd_pkg::PH_DATA: begin
                    n_sum = r_sum + i_byte;
                    if (!r_esc && (i_byte == i_cfg.esc_code)) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc   = 1'b0;
                        n_value = {r_value[srfd_pkg::VALUE_W-srfd_pkg::BYTE_W-1:0], w_data};
                        if (r_idx == srfd_pkg::LAST_PAYLOAD_IDX) begin
                            n_idx   = '0;
                            n_phase = srfd_pkg::PH_SUM;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end
                srfd_pkg::PH_SUM: begin
                    n_phase = srfd_pkg::PH_WAIT;
                    n_addr  = '0;
                    n_idx   = '0;
                    n_esc   = 1'b0;
                    n_value = '0;
                    n_sum   = '0;
                end
                default: begin
                    n_phase = srfd_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // outputs: a result is emitted on the checksum byte
    always_comb begin
        o_stat.phase = r_phase;
        case (r_phase)
            srfd_pkg::PH_SUM: o_stat.emit = 1'b1;
            default:          o_stat.emit = 1'b0;
        endcase
        o_result.reg_address = r_addr;
        o_result.reg_value   = r_value;
        o_result.checksum_ok = (i_byte == r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srfd_pkg::PH_WAIT;
            r_addr  <= '0;
            r_idx   <= '0;
            r_esc   <= 1'b0;
            r_value <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_idx   <= n_idx;
            r_esc   <= n_esc;
            r_value <= n_value;
            r_sum   <= n_sum;
        end
    end
endmodule

FILE: rtl/srfd_out_stage.sv
// result register: holds one decoded frame until the sink takes it
`timescale 1ns / 1ps
module srfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  srfd_pkg::t_result i_result,
    output logic              o_free,
    srfd_result_if.source     o_res
);
    logic              r_valid;
    srfd_pkg::t_result r_result;

    // can load when empty or when the held result transfers this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.reg_address = r_result.reg_address;
    assign o_res.reg_value   = r_result.reg_value;
    assign o_res.checksum_ok = r_result.checksum_ok;
endmodule
